>>> rtl/sbus_frame_receiver_top_defines.svh
// Assertion macros used by the frame receiver checker
`ifndef SBUS_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SBUS_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while in reset
`define SFR_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, ignored while in reset
`define SFR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// Condition that must hold in the cycle after reset is seen
`define SFR_ASSERT_RST(name, post, msg) \
  name: assert property (@(posedge clk) rst |=> (post)) else $error(msg);

`endif

>>> rtl/sfr_pkg.sv
// Constants, types and helpers for the frame receiver
package sfr_pkg;

  localparam int FRAME_BYTES   = 25;
  localparam int CHANNEL_COUNT = 16;
  localparam int CH_BITS       = 11;
  localparam int IDX_W         = $clog2(FRAME_BYTES);
  localparam int CH_W          = $clog2(CHANNEL_COUNT);
  localparam int NBITS_W       = 5;
  localparam int ACC_W         = CH_BITS + 8;

  typedef logic [7:0]          byte_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CH_W-1:0]     ch_t;
  typedef logic [NBITS_W-1:0]  nbits_t;
  typedef logic [ACC_W-1:0]    acc_t;

  localparam byte_t HDR_BYTE  = 8'h0F;
  localparam idx_t  FIRST_POS = idx_t'(1);
  localparam idx_t  FLAG_POS  = idx_t'(23);
  localparam idx_t  FOOT_POS  = idx_t'(FRAME_BYTES - 1);
  localparam ch_t   LAST_CH   = ch_t'(CHANNEL_COUNT - 1);

  function automatic logic footer_ok(input byte_t f);
    return (f == 8'h00) || (f[3:0] == 4'h4);
  endfunction

endpackage

>>> rtl/sbus_frame_receiver_top.sv
// Frame receiver: gathers 25-byte frames and unpacks 16 11-bit channels
//
// Bytes enter one per item on rx_*. Outside a frame a byte is taken in the
// cycle it is offered. When the 25th byte arrives the block drops rx_ready
// and runs one sequence over the 25-entry frame memory (one read port,
// registered data): a good frame first fetches the flag byte, then fetches
// bytes 1..22 one at a time into a 19-bit accumulator and emits a channel
// whenever 11 bits are held, until all 16 results are out; a frame with a
// bad footer instead scans stored bytes 1..24, moving the tail that starts at
// the next header byte to the front of the memory. Results leave through an
// output register, so a result may wait on ch_ready while the block already
// takes the next byte.
module sbus_frame_receiver_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rx_valid,
  output logic                   rx_ready,
  input  logic [7:0]             rx_byte,
  output logic                   ch_valid,
  input  logic                   ch_ready,
  output logic [3:0]             channel_index,
  output logic [10:0]            channel_value,
  output logic                   digital_ch17,
  output logic                   digital_ch18,
  output logic                   frame_lost_flag,
  output logic                   failsafe_flag,
  output logic                   last_channel
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FLAG   = 2'd1;
  localparam logic [1:0] S_UNPACK = 2'd2;
  localparam logic [1:0] S_SCAN   = 2'd3;

  logic [1:0]      state;
  sfr_pkg::idx_t   count;
  sfr_pkg::idx_t   rd_addr;
  sfr_pkg::idx_t   rd_tag;
  logic            rd_ok;
  sfr_pkg::byte_t  rdata;
  logic            found;
  sfr_pkg::idx_t   wptr;
  sfr_pkg::acc_t   acc;
  sfr_pkg::nbits_t nbits;
  sfr_pkg::ch_t    ch;
  logic [3:0]      flags;

  sfr_pkg::byte_t  mem [sfr_pkg::FRAME_BYTES];

  logic            rx_take;
  logic            store_byte;
  logic            scan_hit;
  logic            slot_free;
  logic            emit;
  logic            append;
  logic            mem_we;
  sfr_pkg::idx_t   mem_waddr;
  sfr_pkg::byte_t  mem_wdata;
  sfr_pkg::idx_t   wptr_next;

  assign rx_ready   = (state == S_IDLE);
  assign rx_take    = rx_valid && rx_ready;
  assign store_byte = rx_take && ((count != '0) || (rx_byte == sfr_pkg::HDR_BYTE));
  assign scan_hit   = (state == S_SCAN) && rd_ok && (found || (rdata == sfr_pkg::HDR_BYTE));
  assign slot_free  = !ch_valid || ch_ready;
  assign emit       = (state == S_UNPACK) && (nbits >= sfr_pkg::nbits_t'(sfr_pkg::CH_BITS))
                      && slot_free;
  assign append     = (state == S_UNPACK) && (nbits < sfr_pkg::nbits_t'(sfr_pkg::CH_BITS))
                      && rd_ok;
  assign wptr_next  = found ? wptr + sfr_pkg::idx_t'(1) : sfr_pkg::idx_t'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count;
    mem_wdata = rx_byte;
    priority if (store_byte) begin
      mem_we = 1'b1;
    end else if (scan_hit) begin
      // move the tail down: the header lands at entry 0
      mem_we    = 1'b1;
      mem_waddr = found ? wptr : '0;
      mem_wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata  <= mem[rd_addr];
    rd_tag <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_addr  <= '0;
      rd_ok    <= 1'b0;
      found    <= 1'b0;
      wptr     <= '0;
      ch_valid <= 1'b0;
    end else begin
      if (ch_valid && ch_ready && !emit) begin
        ch_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (store_byte) begin
            if (count == sfr_pkg::FOOT_POS) begin
              count <= '0;
              rd_ok <= 1'b0;
              if (sfr_pkg::footer_ok(rx_byte)) begin
                state   <= S_FLAG;
                rd_addr <= sfr_pkg::FLAG_POS;
              end else begin
                state   <= S_SCAN;
                rd_addr <= sfr_pkg::FIRST_POS;
                found   <= 1'b0;
              end
            end else begin
              count <= count + sfr_pkg::idx_t'(1);
            end
          end
        end
        S_FLAG: begin
          if (rd_ok) begin
            flags   <= rdata[3:0];
            rd_addr <= sfr_pkg::FIRST_POS;
            rd_ok   <= 1'b0;
            acc     <= '0;
            nbits   <= '0;
            ch      <= '0;
            state   <= S_UNPACK;
          end else begin
            rd_ok <= 1'b1;
          end
        end
        S_UNPACK: begin
          if (emit) begin
            ch_valid        <= 1'b1;
            channel_index   <= ch;
            channel_value   <= acc[sfr_pkg::CH_BITS-1:0];
            digital_ch17    <= flags[0];
            digital_ch18    <= flags[1];
            frame_lost_flag <= flags[2];
            failsafe_flag   <= flags[3];
            last_channel    <= (ch == sfr_pkg::LAST_CH);
            acc             <= acc >> sfr_pkg::CH_BITS;
            nbits           <= nbits - sfr_pkg::nbits_t'(sfr_pkg::CH_BITS);
            ch              <= ch + sfr_pkg::ch_t'(1);
            rd_ok           <= 1'b1;
            if (ch == sfr_pkg::LAST_CH) begin
              state <= S_IDLE;
            end
          end else if (append) begin
            acc     <= acc | (sfr_pkg::acc_t'(rdata) << nbits);
            nbits   <= nbits + sfr_pkg::nbits_t'(8);
            rd_addr <= rd_addr + sfr_pkg::idx_t'(1);
            rd_ok   <= 1'b0;
          end else begin
            rd_ok <= 1'b1;
          end
        end
        S_SCAN: begin
          rd_ok <= 1'b1;
          if (rd_addr != sfr_pkg::FOOT_POS) begin
            rd_addr <= rd_addr + sfr_pkg::idx_t'(1);
          end
          if (scan_hit) begin
            found <= 1'b1;
            wptr  <= wptr_next;
          end
          if (rd_ok && (rd_tag == sfr_pkg::FOOT_POS)) begin
            count <= scan_hit ? wptr_next : '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/sfr_checker.sv
// Port-level checks for the frame receiver, bound to the top level
`include "sbus_frame_receiver_top_defines.svh"

module sfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_ready,
  input logic        ch_valid,
  input logic        ch_ready,
  input logic [3:0]  channel_index,
  input logic [10:0] channel_value,
  input logic        digital_ch17,
  input logic        digital_ch18,
  input logic        frame_lost_flag,
  input logic        failsafe_flag,
  input logic        last_channel
);

  logic [19:0] ch_item;
  logic        ch_stall;
  logic        last_match;

  assign ch_item    = {channel_index, channel_value, digital_ch17, digital_ch18,
                       frame_lost_flag, failsafe_flag, last_channel};
  assign ch_stall   = ch_valid && !ch_ready;
  assign last_match = (last_channel == (channel_index == sfr_pkg::LAST_CH));

  `SFR_ASSERT_NEXT(a_out_hold, ch_stall, ch_valid && $stable(ch_item), "stalled item moved")

  `SFR_ASSERT_NOW(a_last_is_ch15, ch_valid, last_match, "last marker not on final channel")

  `SFR_ASSERT_NOW(a_busy_in_frame, ch_valid && !last_channel, !rx_ready, "byte taken mid-frame")

  `SFR_ASSERT_RST(a_reset_idle, rx_ready && !ch_valid, "not idle after reset")

endmodule

bind sbus_frame_receiver_top sfr_checker u_sfr_checker (.*);
